// File: rtl/chm_pkg.sv
// Shared constants, types and helpers for the cache hit/miss block.
`timescale 1ns / 1ps

package chm_pkg;

    localparam int LINES_DEF      = 64;
    localparam int ADDR_BITS_DEF  = 16;

    localparam int CNT_W          = 7;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;
    localparam int LINE_OUT_W     = 6;
    localparam int BLK_OUT_W      = 16;
    localparam int DIV_DW         = 32;
    localparam int DIV_RW         = 9;
    localparam int DIV_NW         = 6;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_USED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAPPING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 3'd4;

    localparam logic [1:0] MAP_DIRECT = 2'd0;
    localparam logic [1:0] MAP_FULL   = 2'd1;

    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_LFU    = 2'd2;
    localparam logic [1:0] POL_LRU    = 2'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_RW-1:0] divisor;
        logic [DIV_NW-1:0] nbits;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic [DIV_RW-1:0] remainder;
    } div_rsp_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] n;
        n = {1'b0, s[15:1]};
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

// File: rtl/chm_ifs.sv
// Handshake channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps

interface chm_req_if #(parameter int AW = chm_pkg::ADDR_BITS_DEF);
    logic          valid;
    logic          ready;
    logic [AW-1:0] word_address;
    modport source (output valid, output word_address, input ready);
    modport sink   (input valid, input word_address, output ready);
endinterface

interface chm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [chm_pkg::LINE_OUT_W-1:0]   line_index;
    logic [chm_pkg::BLK_OUT_W-1:0]    block_number;
    modport source (output valid, output hit, output line_index, output block_number,
                    input ready);
    modport sink   (input valid, input hit, input line_index, input block_number,
                    output ready);
endinterface

interface chm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [chm_pkg::CFG_IDX_W-1:0]   index;
    logic [chm_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/chm_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module chm_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  chm_pkg::div_req_t req,
    output chm_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [chm_pkg::DIV_NW-1:0]     cnt_reg, cnt_next;
    logic [chm_pkg::DIV_DW-1:0]     dvd_reg, dvd_next;
    logic [chm_pkg::DIV_RW-1:0]     dsr_reg, dsr_next;
    logic [chm_pkg::DIV_DW-1:0]     q_reg, q_next;
    logic [chm_pkg::DIV_RW-1:0]     r_reg, r_next;
    logic [chm_pkg::DIV_RW:0]       r_sh;
    logic [chm_pkg::DIV_RW:0]       r_sub;
    logic [4:0]                     bit_idx;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        bit_idx   = 5'(cnt_reg - 6'd1);
        r_sh      = {r_reg, dvd_reg[bit_idx]};
        r_sub     = r_sh - {1'b0, dsr_reg};
        if (busy_reg)
        begin
            if (r_sh >= {1'b0, dsr_reg})
            begin
                r_next = r_sub[chm_pkg::DIV_RW-1:0];
                q_next = {q_reg[chm_pkg::DIV_DW-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[chm_pkg::DIV_RW-1:0];
                q_next = {q_reg[chm_pkg::DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.nbits;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            q_next    = '0;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

// File: rtl/chm_mem.sv
// Line store: one write port, one registered read port.
`timescale 1ns / 1ps

module chm_mem
#(
    parameter int DEPTH = chm_pkg::LINES_DEF,
    parameter int IW    = 6,
    parameter int WIDTH = 97
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [IW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/cache_hit_miss_replacement.sv
// Top level: cache hit/miss tracker with configurable mapping and replacement.
//
// Channels: cfg writes a register (index 0 block size, 1 line count, 2 mapping,
// 3 set count, 4 policy) and is always ready; write it only while idle.
// req carries one word address per item; rsp returns hit, line index and
// block number, one result per item, in order.
// Each item is handled by a sequencer around one shared restoring divider and
// one read port of the line store. It divides for the ways, the block number
// and the set, scans the ways of the set, and, when a random victim is drawn,
// divides the LFSR value by the ways (lfsr mod ways).
// One item is in flight at a time; req is ready only in the idle state.
// The result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds its finished result until rsp is free.
// After reset a clearing pass marks every one of the LINES lines empty; req is
// not ready during it. Counters, stamps and the LFSR return to reset values.
`timescale 1ns / 1ps

module cache_hit_miss_replacement
#(
    parameter int LINES        = chm_pkg::LINES_DEF,
    parameter int ADDRESS_BITS = chm_pkg::ADDR_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    chm_cfg_if.sink    cfg,
    chm_req_if.sink    req,
    chm_rsp_if.source  rsp
);

    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int AW = ADDRESS_BITS;
    localparam int EW = 1 + AW + 16 + 32 + 32;
    localparam int CW = chm_pkg::CNT_W;

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b00000000001,
        ST_IDLE     = 11'b00000000010,
        ST_DIV_WAYS = 11'b00000000100,
        ST_DIV_BLK  = 11'b00000001000,
        ST_DIV_SET  = 11'b00000010000,
        ST_BASE     = 11'b00000100000,
        ST_SCAN     = 11'b00001000000,
        ST_DECIDE   = 11'b00010000000,
        ST_DIV_RND  = 11'b00100000000,
        ST_WRITE    = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]    bw_reg;
    logic [CW-1:0] lu_reg;
    logic [1:0]    mode_reg;
    logic [CW-1:0] sc_reg;
    logic [1:0]    pol_reg;

    logic [8:0]    bw_eff;
    logic [CW-1:0] lines_eff;
    logic [CW-1:0] sets_eff;

    logic [LW-1:0] clr_reg, clr_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] blk_reg, blk_next;
    logic [CW-1:0] ways_reg, ways_next;
    logic [CW-1:0] set_reg, set_next;
    logic [LW-1:0] base_reg, base_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] issued_reg, issued_next;
    logic          pend_reg, pend_next;
    logic [LW-1:0] pidx_reg, pidx_next;
    logic          hit_found_reg, hit_found_next;
    logic [LW-1:0] hit_line_reg, hit_line_next;
    logic [15:0]   hit_use_reg, hit_use_next;
    logic [31:0]   hit_fill_reg, hit_fill_next;
    logic          empty_found_reg, empty_found_next;
    logic [LW-1:0] empty_line_reg, empty_line_next;
    logic [LW-1:0] best_line_reg, best_line_next;
    logic [31:0]   best_key_reg, best_key_next;
    logic [LW-1:0] line_reg, line_next;
    logic [31:0]   clk_reg, clk_next;
    logic [15:0]   lfsr_reg, lfsr_next;
    logic          div_started_reg, div_started_next;

    logic                           ovalid_reg, ovalid_next;
    logic                           ohit_reg, ohit_next;
    logic [chm_pkg::LINE_OUT_W-1:0] oline_reg, oline_next;
    logic [chm_pkg::BLK_OUT_W-1:0]  oblk_reg, oblk_next;

    chm_pkg::div_req_t div_req;
    chm_pkg::div_rsp_t div_rsp;

    logic          mem_we;
    logic [LW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [LW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic          rd_valid;
    logic [AW-1:0] rd_block;
    logic [15:0]   rd_use;
    logic [31:0]   rd_fill;
    logic [31:0]   rd_last;
    logic [31:0]   age_diff;
    logic [15:0]   age;
    logic [31:0]   rd_key;
    logic [13:0]   base_prod;
    logic [15:0]   use_inc;

    chm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    chm_mem #(.DEPTH(LINES), .IW(LW), .WIDTH(EW)) u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg   <= 9'd1;
            lu_reg   <= 7'd64;
            mode_reg <= chm_pkg::MAP_DIRECT;
            sc_reg   <= 7'd1;
            pol_reg  <= chm_pkg::POL_FIFO;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                chm_pkg::REG_BLOCK_WORDS: bw_reg   <= cfg.data;
                chm_pkg::REG_LINES_USED:  lu_reg   <= cfg.data[CW-1:0];
                chm_pkg::REG_MAPPING:     mode_reg <= cfg.data[1:0];
                chm_pkg::REG_SET_COUNT:   sc_reg   <= cfg.data[CW-1:0];
                chm_pkg::REG_POLICY:      pol_reg  <= cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (bw_reg == 9'd0)
            bw_eff = 9'd1;
        else if (bw_reg > 9'd256)
            bw_eff = 9'd256;
        else
            bw_eff = bw_reg;

        if (lu_reg == '0)
            lines_eff = 7'd1;
        else if (32'(lu_reg) > 32'(LINES))
            lines_eff = CW'(LINES);
        else
            lines_eff = lu_reg;

        if (mode_reg == chm_pkg::MAP_DIRECT)
            sets_eff = lines_eff;
        else if (mode_reg == chm_pkg::MAP_FULL)
            sets_eff = 7'd1;
        else if (sc_reg == '0)
            sets_eff = 7'd1;
        else if (sc_reg > lines_eff)
            sets_eff = lines_eff;
        else
            sets_eff = sc_reg;
    end

    // line store entry fields
    assign rd_valid = mem_rdata[EW-1];
    assign rd_block = mem_rdata[EW-2 -: AW];
    assign rd_use   = mem_rdata[79:64];
    assign rd_fill  = mem_rdata[63:32];
    assign rd_last  = mem_rdata[31:0];
    assign age_diff = clk_reg - rd_fill;
    assign age      = (age_diff > 32'h0000FFFF) ? 16'hFFFF : age_diff[15:0];

    always_comb
    begin
        case (pol_reg)
            chm_pkg::POL_FIFO: rd_key = {16'h0000, 16'hFFFF - age};
            chm_pkg::POL_LFU:  rd_key = {16'h0000, rd_use};
            default:           rd_key = rd_last;
        endcase
    end

    assign base_prod = 14'(set_reg) * 14'(ways_reg);
    assign use_inc   = (hit_use_reg == 16'hFFFF) ? hit_use_reg : hit_use_reg + 16'd1;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        addr_next        = addr_reg;
        blk_next         = blk_reg;
        ways_next        = ways_reg;
        set_next         = set_reg;
        base_next        = base_reg;
        ptr_next         = ptr_reg;
        issued_next      = issued_reg;
        pend_next        = pend_reg;
        pidx_next        = pidx_reg;
        hit_found_next   = hit_found_reg;
        hit_line_next    = hit_line_reg;
        hit_use_next     = hit_use_reg;
        hit_fill_next    = hit_fill_reg;
        empty_found_next = empty_found_reg;
        empty_line_next  = empty_line_reg;
        best_line_next   = best_line_reg;
        best_key_next    = best_key_reg;
        line_next        = line_reg;
        clk_next         = clk_reg;
        lfsr_next        = lfsr_reg;
        div_started_next = div_started_reg;
        ovalid_next      = ovalid_reg;
        ohit_next        = ohit_reg;
        oline_next       = oline_reg;
        oblk_next        = oblk_reg;

        div_req          = '0;
        mem_we           = 1'b0;
        mem_waddr        = line_reg;
        mem_wdata        = '0;
        mem_raddr        = ptr_reg;

        if (rsp.valid && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == LW'(LINES - 1))
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + LW'(1);
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next  = req.word_address;
                    clk_next   = clk_reg + 32'd1;
                    state_next = ST_DIV_WAYS;
                end
            end
            ST_DIV_WAYS:
            begin
                div_req.start    = !div_started_reg;
                div_req.dividend = 32'(lines_eff);
                div_req.divisor  = 9'(sets_eff);
                div_req.nbits    = 6'(CW);
                if (div_req.start)
                    div_started_next = 1'b1;
                if (div_rsp.done)
                begin
                    div_started_next = 1'b0;
                    ways_next        = div_rsp.quotient[CW-1:0];
                    state_next       = ST_DIV_BLK;
                end
            end
            ST_DIV_BLK:
            begin
                div_req.start    = !div_started_reg;
                div_req.dividend = 32'(addr_reg);
                div_req.divisor  = bw_eff;
                div_req.nbits    = 6'(AW);
                if (div_req.start)
                    div_started_next = 1'b1;
                if (div_rsp.done)
                begin
                    div_started_next = 1'b0;
                    blk_next         = div_rsp.quotient[AW-1:0];
                    state_next       = ST_DIV_SET;
                end
            end
            ST_DIV_SET:
            begin
                div_req.start    = !div_started_reg;
                div_req.dividend = 32'(blk_reg);
                div_req.divisor  = 9'(sets_eff);
                div_req.nbits    = 6'(AW);
                if (div_req.start)
                    div_started_next = 1'b1;
                if (div_rsp.done)
                begin
                    div_started_next = 1'b0;
                    set_next         = div_rsp.remainder[CW-1:0];
                    state_next       = ST_BASE;
                end
            end
            ST_BASE:
            begin
                base_next        = LW'(base_prod);
                ptr_next         = LW'(base_prod);
                issued_next      = '0;
                pend_next        = 1'b0;
                hit_found_next   = 1'b0;
                empty_found_next = 1'b0;
                state_next       = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issued_reg < ways_reg)
                begin
                    issued_next = issued_reg + CW'(1);
                    ptr_next    = ptr_reg + LW'(1);
                    pend_next   = 1'b1;
                    pidx_next   = ptr_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (!hit_found_reg && rd_valid && rd_block == blk_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_line_next  = pidx_reg;
                        hit_use_next   = rd_use;
                        hit_fill_next  = rd_fill;
                    end
                    if (!empty_found_reg && !rd_valid)
                    begin
                        empty_found_next = 1'b1;
                        empty_line_next  = pidx_reg;
                    end
                    if (pidx_reg == base_reg || rd_key < best_key_reg)
                    begin
                        best_line_next = pidx_reg;
                        best_key_next  = rd_key;
                    end
                end
                else if (issued_reg == ways_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (hit_found_reg)
                begin
                    line_next  = hit_line_reg;
                    state_next = ST_WRITE;
                end
                else if (empty_found_reg)
                begin
                    line_next  = empty_line_reg;
                    state_next = ST_WRITE;
                end
                else if (pol_reg == chm_pkg::POL_RANDOM)
                begin
                    lfsr_next  = chm_pkg::lfsr_step(lfsr_reg);
                    state_next = ST_DIV_RND;
                end
                else
                begin
                    line_next  = best_line_reg;
                    state_next = ST_WRITE;
                end
            end
            ST_DIV_RND:
            begin
                div_req.start    = !div_started_reg;
                div_req.dividend = 32'(lfsr_reg);
                div_req.divisor  = 9'(ways_reg);
                div_req.nbits    = 6'd16;
                if (div_req.start)
                    div_started_next = 1'b1;
                if (div_rsp.done)
                begin
                    div_started_next = 1'b0;
                    line_next        = base_reg + LW'(div_rsp.remainder);
                    state_next       = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = line_reg;
                if (hit_found_reg)
                    mem_wdata = {1'b1, blk_reg, use_inc, hit_fill_reg, clk_reg};
                else
                    mem_wdata = {1'b1, blk_reg, 16'h0000, clk_reg, clk_reg};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ohit_next   = hit_found_reg;
                    oline_next  = chm_pkg::LINE_OUT_W'(line_reg);
                    oblk_next   = chm_pkg::BLK_OUT_W'(blk_reg);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            issued_reg      <= '0;
            pend_reg        <= 1'b0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            clk_reg         <= '0;
            lfsr_reg        <= chm_pkg::LFSR_SEED;
            div_started_reg <= 1'b0;
            ovalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            issued_reg      <= issued_next;
            pend_reg        <= pend_next;
            hit_found_reg   <= hit_found_next;
            empty_found_reg <= empty_found_next;
            clk_reg         <= clk_next;
            lfsr_reg        <= lfsr_next;
            div_started_reg <= div_started_next;
            ovalid_reg      <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        blk_reg        <= blk_next;
        ways_reg       <= ways_next;
        set_reg        <= set_next;
        base_reg       <= base_next;
        ptr_reg        <= ptr_next;
        pidx_reg       <= pidx_next;
        hit_line_reg   <= hit_line_next;
        hit_use_reg    <= hit_use_next;
        hit_fill_reg   <= hit_fill_next;
        empty_line_reg <= empty_line_next;
        best_line_reg  <= best_line_next;
        best_key_reg   <= best_key_next;
        line_reg       <= line_next;
        ohit_reg       <= ohit_next;
        oline_reg      <= oline_next;
        oblk_reg       <= oblk_next;
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.hit          = ohit_reg;
    assign rsp.line_index   = oline_reg;
    assign rsp.block_number = oblk_reg;

    // an accepted item always starts with the ways division
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_DIV_WAYS))
        else $error("accepted item did not start the sequencer");

    // divider finishes only for a division the sequencer started
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> div_started_reg)
        else $error("divider result without a request");

    // the scan never reads past the selected set
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issued_reg <= ways_reg))
        else $error("scan ran past the set");

    // a finished result is never dropped while the output is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid)
        else $error("stalled result lost");

endmodule

// File: dv/testbench.sv
// Testbench for the cache hit/miss block: directed and random address streams against a predictor.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic        hit;
        logic [5:0]  line_index;
        logic [15:0] block_number;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   mismatches = 0;
    int   received = 0;
    int   sent = 0;
    bit   tol_gap = 1'b1;
    lookup_t expected_q[$];

    chm_cfg_if cfg ();
    chm_req_if req ();
    chm_rsp_if rsp ();

    cache_hit_miss_replacement i_dut (.clk(clk), .rst_n(rst_n), .cfg(cfg), .req(req), .rsp(rsp));

    always #1 clk = ~clk;

    // predictor state
    int unsigned m_bw, m_lines, m_map, m_sets, m_pol;
    bit          p_valid[64];
    logic [15:0] p_block[64];
    logic [15:0] p_use[64];
    logic [15:0] p_age[64];
    logic [31:0] p_last[64];
    logic [31:0] p_clock;
    logic [15:0] p_lfsr;

    function automatic logic [15:0] next_lfsr(input logic [15:0] s);
        logic [15:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ 16'hB400;
        end
        return n;
    endfunction

    function automatic void predictor_reset();
        m_bw = 1;
        m_lines = 64;
        m_map = chm_pkg::MAP_DIRECT;
        m_sets = 1;
        m_pol = chm_pkg::POL_FIFO;
        for (int j = 0; j < 64; j++)
        begin
            p_valid[j] = 1'b0;
            p_block[j] = '0;
            p_use[j] = '0;
            p_age[j] = '0;
            p_last[j] = '0;
        end
        p_clock = '0;
        p_lfsr = 16'hACE1;
    endfunction

    function automatic lookup_t predict_lookup(input logic [15:0] addr);
        int unsigned bw, lines, sets, ways, base, line, blk, best;
        bit hit, found;
        lookup_t r;
        bw = (m_bw == 0) ? 1 : (m_bw > 256 ? 256 : m_bw);
        lines = (m_lines == 0) ? 1 : (m_lines > 64 ? 64 : m_lines);
        if (m_map == chm_pkg::MAP_DIRECT)
        begin
            sets = lines;
        end
        else if (m_map == chm_pkg::MAP_FULL)
        begin
            sets = 1;
        end
        else
        begin
            sets = (m_sets == 0) ? 1 : m_sets;
            if (sets > lines)
            begin
                sets = lines;
            end
        end
        ways = lines / sets;
        blk = addr / bw;
        base = (blk % sets) * ways;
        p_clock = p_clock + 1;
        hit = 1'b0;
        found = 1'b0;
        line = 0;
        for (int unsigned j = base; j < base + ways; j++)
        begin
            if (!hit && p_valid[j] && p_block[j] == blk)
            begin
                hit = 1'b1;
                line = j;
            end
        end
        if (hit)
        begin
            if (p_use[line] != 16'hFFFF)
            begin
                p_use[line]++;
            end
            p_last[line] = p_clock;
        end
        else
        begin
            for (int unsigned j = base; j < base + ways; j++)
            begin
                if (!found && !p_valid[j])
                begin
                    found = 1'b1;
                    line = j;
                end
            end
            if (!found)
            begin
                best = base;
                if (m_pol == chm_pkg::POL_RANDOM)
                begin
                    p_lfsr = next_lfsr(p_lfsr);
                    best = base + p_lfsr % ways;
                end
                else
                begin
                    for (int unsigned j = base + 1; j < base + ways; j++)
                    begin
                        if ((m_pol == chm_pkg::POL_FIFO && p_age[j] > p_age[best])
                            || (m_pol == chm_pkg::POL_LFU && p_use[j] < p_use[best])
                            || (m_pol == chm_pkg::POL_LRU && p_last[j] < p_last[best]))
                        begin
                            best = j;
                        end
                    end
                end
                line = best;
            end
            p_valid[line] = 1'b1;
            p_block[line] = blk;
            p_use[line] = '0;
            p_age[line] = '0;
            p_last[line] = p_clock;
        end
        for (int j = 0; j < 64; j++)
        begin
            if (p_valid[j] && p_age[j] != 16'hFFFF)
            begin
                p_age[j]++;
            end
        end
        r.hit = hit;
        r.line_index = line[5:0];
        r.block_number = blk[15:0];
        return r;
    endfunction

    function automatic int gap_len();
        if (!tol_gap)
        begin
            return 0;
        end
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    endfunction

    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        req.valid = 1'b0;
        req.word_address = '0;
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result checker and random stall on the result side
    int stall = 0;
    always @(posedge clk)
    begin
        lookup_t exp_r;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                received <= received + 1;
                if (expected_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("unexpected item: hit %0d line %0d block %0d",
                                 rsp.hit, rsp.line_index, rsp.block_number);
                    end
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (rsp.hit !== exp_r.hit || rsp.line_index !== exp_r.line_index
                        || rsp.block_number !== exp_r.block_number)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("mismatch: exp hit %0d line %0d block %0d, got %0d %0d %0d",
                                     exp_r.hit, exp_r.line_index, exp_r.block_number,
                                     rsp.hit, rsp.line_index, rsp.block_number);
                        end
                    end
                end
            end
            if (stall > 0)
            begin
                stall <= stall - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                stall <= gap_len();
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value[8:0];
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        case (idx)
            chm_pkg::REG_BLOCK_WORDS: m_bw = value & 9'h1FF;
            chm_pkg::REG_LINES_USED:  m_lines = value & 7'h7F;
            chm_pkg::REG_MAPPING:     m_map = value & 3;
            chm_pkg::REG_SET_COUNT:   m_sets = value & 7'h7F;
            default:                  m_pol = value & 3;
        endcase
        @(posedge clk);
    endtask

    task automatic send_address(input logic [15:0] addr);
        int g;
        g = gap_len();
        repeat (g + 1) @(posedge clk);
        req.valid <= 1'b1;
        req.word_address <= addr;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        expected_q = {expected_q, predict_lookup(addr)};
        sent++;
        req.valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
    endtask

    task automatic setup(input int unsigned bw, input int unsigned ln, input int unsigned mp,
                         input int unsigned sc, input int unsigned pl);
        drain();
        write_reg(chm_pkg::REG_BLOCK_WORDS, bw);
        write_reg(chm_pkg::REG_LINES_USED, ln);
        write_reg(chm_pkg::REG_MAPPING, mp);
        write_reg(chm_pkg::REG_SET_COUNT, sc);
        write_reg(chm_pkg::REG_POLICY, pl);
    endtask

    task automatic test_directed();
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'h0000);
        send_address(16'h5555);
        send_address(16'hAAAA);
        setup(0, 0, 3, 0, 0);
        send_address(16'h1234);
        send_address(16'h1235);
        setup(511, 127, 2, 127, 2);
        send_address(16'hFFFF);
        send_address(16'h00FF);
        setup(256, 64, 1, 1, 3);
        for (int k = 0; k < 5; k++)
        begin
            send_address(16'(k * 256));
        end
        setup(3, 10, 2, 4, 1);
        send_address(16'h0007);
        send_address(16'hFFF0);
        send_address(16'h0007);
    endtask

    task automatic test_random();
        int unsigned pool;
        for (int phase = 0; phase < 8; phase++)
        begin
            tol_gap = (phase != 3);
            setup($urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 3),
                  $urandom_range(0, 127) % ((phase % 2) ? 128 : 9), phase % 4);
            pool = $urandom_range(2, 80);
            for (int k = 0; k < 50; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_address(16'($urandom()));
                end
                else
                begin
                    send_address(16'($urandom_range(0, pool) * (m_bw == 0 ? 1 : m_bw)));
                end
            end
        end
        tol_gap = 1'b1;
    endtask

    initial
    begin
        predictor_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        drain();
        if (mismatches == 0 && received == sent)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/chm_pkg.sv
rtl/chm_ifs.sv
rtl/chm_div.sv
rtl/chm_mem.sv
rtl/cache_hit_miss_replacement.sv
dv/testbench.sv
